// File: sv/ple_pkg.sv
// Shared constants, command codes and data conversion helpers for the
// positional list engine. No dependencies.
package ple_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  // wide enough for port positions and the count, plus one guard bit
  localparam int CMP_W  = ((CNT_W > 7) ? CNT_W : 7) + 1;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_READ   = 3'd2,
    CMD_FIND   = 3'd3,
    CMD_COUNT  = 3'd4
  } cmd_t;

  // sign-extend the 32-bit port value, keep DATA_WIDTH bits
  function automatic logic [DATA_WIDTH-1:0] from_in(input logic [31:0] v);
    logic [63:0] w;
    w = {{32{v[31]}}, v};
    return w[DATA_WIDTH-1:0];
  endfunction

  // sign-extend a stored element from DATA_WIDTH bits, give the low 32 bits
  function automatic logic [31:0] to_out(input logic [DATA_WIDTH-1:0] s);
    logic [31:0] r;
    int          j;
    r = '0;
    for (int k = 0; k < 32; k++) begin
      j = (k < DATA_WIDTH) ? k : DATA_WIDTH - 1;
      r[k] = s[j];
    end
    return r;
  endfunction

endpackage

// File: sv/ple_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/positional_list_engine_unit.sv
// Top level of the positional list engine: command sequencer around one RAM.
// Depends on ple_pkg and ple_ram.
//
// Usage: drive in_command, in_position and in_value and raise start; the
// transaction is taken at a clock edge where start is high and busy is low.
// busy stays high until the result has been shown. The result appears on
// out_ok, out_read_value, out_found_position and out_count for exactly one
// cycle, flagged by out_valid; the receiver cannot stall it and must take it
// in that cycle. busy falls in the cycle after the result strobe.
// Sequence from acceptance to the strobe: a count report, an unknown or
// failing command goes straight to the strobe; a read sets the RAM address,
// then takes the data; an insert below the end shifts each element up one
// place, then writes the value; a delete shifts each later element down;
// a find reads and compares from the first element until a match or the end.
// Every element move and compare goes through the single RAM port pair,
// a read and then a write for each move. Reset clears the element count to
// zero and returns the sequencer to idle; the RAM contents are not cleared.
module positional_list_engine_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_command,
  input  logic [6:0]         in_position,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic               out_ok,
  output logic signed [31:0] out_read_value,
  output logic [6:0]         out_found_position,
  output logic [6:0]         out_count
);
  import ple_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_SH_RD   = 9'b000000010,
    ST_SH_WR   = 9'b000000100,
    ST_WR_VAL  = 9'b000001000,
    ST_RD_ADDR = 9'b000010000,
    ST_RD_DATA = 9'b000100000,
    ST_FD_RD   = 9'b001000000,
    ST_FD_CMP  = 9'b010000000,
    ST_FIN     = 9'b100000000
  } state_t;

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [ADDR_W-1:0]     pos0_r, pos0_nxt;
  logic [ADDR_W-1:0]     dst_r, dst_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  ok_r, ok_nxt;
  logic [31:0]           rd_r, rd_nxt;
  logic [CNT_W-1:0]      found_r, found_nxt;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr, src_addr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  logic [CMP_W-1:0]      pos_ext, pos_m1, cnt_ext, cnt_inc, dst_ext, cnt_out, fnd_out;

  ple_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pos_ext = CMP_W'(in_position);
  assign pos_m1  = pos_ext - CMP_W'(1);
  assign cnt_ext = CMP_W'(count_r);
  assign cnt_inc = cnt_ext + CMP_W'(1);
  assign dst_ext = CMP_W'(dst_r);

  // insert copies downward-adjacent entry up; delete pulls the next one down
  assign src_addr = (cmd_r == CMD_INSERT) ? dst_r - ADDR_W'(1) : dst_r + ADDR_W'(1);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    pos0_nxt  = pos0_r;
    dst_nxt   = dst_r;
    val_nxt   = val_r;
    count_nxt = count_r;
    ok_nxt    = ok_r;
    rd_nxt    = rd_r;
    found_nxt = found_r;
    ram_we    = 1'b0;
    ram_waddr = dst_r;
    ram_wdata = ram_rdata;
    ram_raddr = src_addr;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt   = cmd_t'(in_command);
          pos0_nxt  = pos_m1[ADDR_W-1:0];
          val_nxt   = from_in(in_value);
          ok_nxt    = 1'b0;
          rd_nxt    = '0;
          found_nxt = '0;
          state_nxt = ST_FIN;
          case (cmd_t'(in_command))
            CMD_INSERT: begin
              if (pos_ext != '0 && pos_ext <= cnt_inc && cnt_ext < CMP_W'(CAPACITY)) begin
                if (pos_ext == cnt_inc) begin
                  state_nxt = ST_WR_VAL;
                end else begin
                  dst_nxt   = count_r[ADDR_W-1:0];
                  state_nxt = ST_SH_RD;
                end
              end
            end
            CMD_DELETE: begin
              if (pos_ext != '0 && pos_ext <= cnt_ext) begin
                if (pos_ext == cnt_ext) begin
                  count_nxt = count_r - CNT_W'(1);
                  ok_nxt    = 1'b1;
                end else begin
                  dst_nxt   = pos_m1[ADDR_W-1:0];
                  state_nxt = ST_SH_RD;
                end
              end
            end
            CMD_READ: begin
              if (pos_ext != '0 && pos_ext <= cnt_ext) begin
                state_nxt = ST_RD_ADDR;
              end
            end
            CMD_FIND: begin
              if (count_r != '0) begin
                dst_nxt   = '0;
                state_nxt = ST_FD_RD;
              end
            end
            CMD_COUNT: begin
              ok_nxt = 1'b1;
            end
            default: begin
              ok_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_SH_RD: begin
        ram_raddr = src_addr;
        state_nxt = ST_SH_WR;
      end
      ST_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = dst_r;
        ram_wdata = ram_rdata;
        if (cmd_r == CMD_INSERT) begin
          if (src_addr == pos0_r) begin
            state_nxt = ST_WR_VAL;
          end else begin
            dst_nxt   = src_addr;
            state_nxt = ST_SH_RD;
          end
        end else begin
          if (dst_ext + CMP_W'(2) == cnt_ext) begin
            count_nxt = count_r - CNT_W'(1);
            ok_nxt    = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            dst_nxt   = src_addr;
            state_nxt = ST_SH_RD;
          end
        end
      end
      ST_WR_VAL: begin
        ram_we    = 1'b1;
        ram_waddr = pos0_r;
        ram_wdata = val_r;
        count_nxt = count_r + CNT_W'(1);
        ok_nxt    = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_RD_ADDR: begin
        ram_raddr = pos0_r;
        state_nxt = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        rd_nxt    = to_out(ram_rdata);
        ok_nxt    = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FD_RD: begin
        ram_raddr = dst_r;
        state_nxt = ST_FD_CMP;
      end
      ST_FD_CMP: begin
        if (ram_rdata == val_r) begin
          found_nxt = CNT_W'(dst_r) + CNT_W'(1);
          ok_nxt    = 1'b1;
          state_nxt = ST_FIN;
        end else if (dst_ext + CMP_W'(1) == cnt_ext) begin
          state_nxt = ST_FIN;
        end else begin
          dst_nxt   = dst_r + ADDR_W'(1);
          state_nxt = ST_FD_RD;
        end
      end
      ST_FIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    pos0_r  <= pos0_nxt;
    dst_r   <= dst_nxt;
    val_r   <= val_nxt;
    ok_r    <= ok_nxt;
    rd_r    <= rd_nxt;
    found_r <= found_nxt;
  end

  assign cnt_out = CMP_W'(count_r);
  assign fnd_out = CMP_W'(found_r);

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = (state_r == ST_FIN);
  assign out_ok             = ok_r;
  assign out_read_value     = rd_r;
  assign out_found_position = fnd_out[6:0];
  assign out_count          = cnt_out[6:0];

`ifndef SYNTHESIS
  // one result per transaction: the result strobe is never held
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  a_found_implies_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found_position != 7'd0) |-> out_ok)
    else $error("found position reported without ok");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_ext <= CMP_W'(CAPACITY))
    else $error("element count exceeds capacity");
`endif

endmodule
